### rtl/core/sqtraj_pkg.sv
// Shared types, constants and helpers for the square cubic trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

package sqtraj_pkg;

  localparam int unsigned TIME_BITS_DEF = 20;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned LEG_W         = 3;
  localparam int unsigned WEIGHT_BITS   = 24;
  localparam int unsigned WGT_W         = WEIGHT_BITS + 1;
  localparam int unsigned MUL_A_W       = POS_W;
  localparam int unsigned MUL_B_W       = WGT_W;
  localparam int unsigned PROD_W        = MUL_A_W + MUL_B_W;
  localparam int unsigned EXT_W         = POS_W + 4;
  localparam int unsigned LEG_TICKS_RST = 1000;

  localparam logic [LEG_W-1:0] LEG_IDLE   = 3'd0;
  localparam logic [LEG_W-1:0] LEG_X_OUT  = 3'd1;
  localparam logic [LEG_W-1:0] LEG_Y_OUT  = 3'd2;
  localparam logic [LEG_W-1:0] LEG_X_BACK = 3'd3;
  localparam logic [LEG_W-1:0] LEG_Y_BACK = 3'd4;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic signed [EXT_W-1:0] POS_MAX_EXT = 36'sh0_7FFF_FFFF;
  localparam logic signed [EXT_W-1:0] POS_MIN_EXT = 36'shF_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEG_DX,
    REG_LEG_DY,
    REG_TICKS_X,
    REG_TICKS_Y
  } sqtraj_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CALC,
    ST_EMIT
  } sqtraj_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV,
    C_SQ,
    C_CUBE,
    C_WEIGHT,
    C_SCALE,
    C_SUM
  } sqtraj_calc_e;

  typedef struct packed {
    logic start;
    logic neg;
  } sqtraj_req_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX_EXT) begin
      r = POS_MAX_EXT[POS_W-1:0];
    end else if (v < POS_MIN_EXT) begin
      r = POS_MIN_EXT[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sqtraj_calc.sv
// Iterative blend unit: divider, shared multiplier and rounding for one leg position.
`timescale 1ns / 1ps
`default_nettype none

module sqtraj_calc import sqtraj_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  sqtraj_req_t                   req_i,
  input  wire        [TIME_BITS-1:0]    elapsed_i,
  input  wire        [TIME_BITS-1:0]    ticks_i,
  input  wire        [POS_W-1:0]        mag_i,
  input  wire signed [POS_W-1:0]        base_i,
  output logic                          done_o,
  output logic signed [POS_W-1:0]       pos_o
);

  localparam int unsigned CNT_W = $clog2(WEIGHT_BITS);
  localparam int unsigned RND_W = PROD_W + 1 - WEIGHT_BITS;
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (WEIGHT_BITS - 1);

  sqtraj_calc_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [TIME_BITS-1:0] rem_q, ticks_q;
  logic [WEIGHT_BITS-1:0] quo_q, s2_q;
  logic [WGT_W-1:0] wgt_q;
  logic [PROD_W-1:0] prod_q;
  logic [POS_W-1:0] mag_q;
  logic signed [POS_W-1:0] base_q, pos_q;
  logic neg_q;

  logic [TIME_BITS:0] rem_sh, rem_sub;
  logic rem_ge;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [WEIGHT_BITS-1:0] s3;
  logic [WGT_W+1:0] wgt;
  logic [PROD_W:0] rnd;
  logic [RND_W-1:0] step;
  logic signed [EXT_W-1:0] base_ext, step_ext, sum;

  // One restoring division step per cycle on the remainder.
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, ticks_q};
  assign rem_sub = rem_sh - {1'b0, ticks_q};

  always_comb begin
    unique case (state_q)
      C_SQ: begin
        mul_a = MUL_A_W'(quo_q);
        mul_b = MUL_B_W'(quo_q);
      end
      C_CUBE: begin
        mul_a = MUL_A_W'(prod_q[2*WEIGHT_BITS-1:WEIGHT_BITS]);
        mul_b = MUL_B_W'(quo_q);
      end
      default: begin
        mul_a = mag_q;
        mul_b = wgt_q;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign s3  = prod_q[2*WEIGHT_BITS-1:WEIGHT_BITS];
  assign wgt = ({2'b00, s2_q, 1'b0} + {3'b000, s2_q}) - {2'b00, s3, 1'b0};

  // Round the magnitude to nearest, ties away from zero, then apply the sign.
  assign rnd      = {1'b0, prod_q} + HALF;
  assign step     = rnd[PROD_W:WEIGHT_BITS];
  assign base_ext = {{(EXT_W - POS_W){base_q[POS_W-1]}}, base_q};
  assign step_ext = EXT_W'(step);
  assign sum      = neg_q ? (base_ext - step_ext) : (base_ext + step_ext);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          cnt_d   = CNT_W'(WEIGHT_BITS - 1);
          state_d = C_DIV;
        end
      end
      C_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = C_SQ;
        end
      end
      C_SQ:     state_d = C_CUBE;
      C_CUBE:   state_d = C_WEIGHT;
      C_WEIGHT: state_d = C_SCALE;
      C_SCALE:  state_d = C_SUM;
      C_SUM: begin
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          rem_q   <= elapsed_i;
          ticks_q <= ticks_i;
          mag_q   <= mag_i;
          base_q  <= base_i;
          neg_q   <= req_i.neg;
        end
      end
      C_DIV: begin
        quo_q <= {quo_q[WEIGHT_BITS-2:0], rem_ge};
        rem_q <= rem_ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      end
      C_SQ: prod_q <= mul_p;
      C_CUBE: begin
        s2_q   <= prod_q[2*WEIGHT_BITS-1:WEIGHT_BITS];
        prod_q <= mul_p;
      end
      C_WEIGHT: wgt_q <= wgt[WGT_W-1:0];
      C_SCALE:  prod_q <= mul_p;
      C_SUM:    pos_q <= sat_pos(sum);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign pos_o  = pos_q;

endmodule

`default_nettype wire

### rtl/core/square_cubic_trajectory_generator.sv
// Top level of the square XY setpoint generator built from four cubic legs.
//
// Input stream: tuser carries the command (0 tick, 1 start); tdata carries the
// start corner, X in bits 31:0 and Y in bits 63:32, used only on a start.
// Output stream: one result per input transaction. tdata holds the X and Y
// setpoints in Q16.16, tuser the current leg (0 idle, 1 to 4) and the done flag.
// Legs run X out, Y out, X back, Y back, each over its configured tick count.
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_data_i and are
// applied at once; the user must make them while the block is idle (not enforced).
// Steps: a start, a tick while idle or done, or a tick that ends a leg goes from
// decide straight to the output load; a tick inside a leg runs decide, a bit-serial
// divide, three shared-multiplier passes, weight, rounding, write-back and output
// load. Input is ready again only after the output load.
// One transaction is in flight at a time; the next is taken once the result has
// moved to the output register. A stalled receiver holds the result in that
// register and input is refused after one further transaction.
// Reset clears the configuration to zero sides and 1000-tick legs, the setpoint
// to zero and the leg to idle.
`timescale 1ns / 1ps
`default_nettype none

module square_cubic_trajectory_generator import sqtraj_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [63:0]          s_axis_tdata,   // start_x [31:0], start_y [63:32]
  input  wire                  s_axis_tuser,   // command [0]
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // pos_x [31:0], pos_y [63:32]
  output logic [3:0]           m_axis_tuser,   // leg [2:0], done_res [3]
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [CFG_W-1:0]     cfg_data_i
);

  sqtraj_state_e state_q, state_d;

  logic signed [POS_W-1:0] leg_dx_q, leg_dy_q;
  logic [TIME_BITS-1:0] ticks_x_q, ticks_y_q;

  logic cmd_q, cmd_d;
  logic signed [POS_W-1:0] in_x_q, in_x_d, in_y_q, in_y_d;
  logic signed [POS_W-1:0] corner_x_q, corner_x_d, corner_y_q, corner_y_d;
  logic signed [POS_W-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [LEG_W-1:0] leg_q, leg_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d, e_q, e_d;
  logic finished_q, finished_d;
  logic calc_x_q, calc_x_d;
  logic m_valid_q, m_valid_d;
  logic [63:0] m_data_q, m_data_d;
  logic [3:0] m_user_q, m_user_d;

  logic in_acc, out_free;
  logic is_x, going_out, active, move, neg;
  logic [TIME_BITS-1:0] t_sel;
  logic signed [POS_W-1:0] c_sel, d_sel, end_pt, p0, p1;
  logic [POS_W:0] d_abs;
  logic [TIME_BITS:0] e_full;
  sqtraj_req_t req;
  logic calc_done;
  logic signed [POS_W-1:0] calc_pos;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Leg geometry, formed from registered state in the decide cycle.
  assign is_x      = (leg_q == LEG_X_OUT) || (leg_q == LEG_X_BACK);
  assign going_out = (leg_q == LEG_X_OUT) || (leg_q == LEG_Y_OUT);
  assign active    = (leg_q != LEG_IDLE) && !finished_q;
  assign t_sel     = is_x ? ticks_x_q : ticks_y_q;
  assign c_sel     = is_x ? corner_x_q : corner_y_q;
  assign d_sel     = is_x ? leg_dx_q : leg_dy_q;
  assign end_pt    = sat_pos(EXT_W'(c_sel) + EXT_W'(d_sel));
  assign p0        = going_out ? c_sel : end_pt;
  assign p1        = going_out ? end_pt : c_sel;
  assign d_abs     = d_sel[POS_W-1] ? -{d_sel[POS_W-1], d_sel} : {1'b0, d_sel};
  // The return legs run the side length backwards.
  assign neg       = d_sel[POS_W-1] ^ !going_out;
  assign e_full    = {1'b0, elapsed_q} + 1'b1;
  assign move      = e_full < {1'b0, t_sel};

  sqtraj_calc #(
    .TIME_BITS (TIME_BITS)
  ) u_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .elapsed_i (e_full[TIME_BITS-1:0]),
    .ticks_i   (t_sel),
    .mag_i     (d_abs[POS_W-1:0]),
    .base_i    (p0),
    .done_o    (calc_done),
    .pos_o     (calc_pos)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    in_x_d     = in_x_q;
    in_y_d     = in_y_q;
    corner_x_d = corner_x_q;
    corner_y_d = corner_y_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    leg_d      = leg_q;
    elapsed_d  = elapsed_q;
    finished_d = finished_q;
    calc_x_d   = calc_x_q;
    e_d        = e_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    req        = '0;
    req.neg    = neg;
    s_axis_tready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = s_axis_tuser;
          in_x_d  = s_axis_tdata[31:0];
          in_y_d  = s_axis_tdata[63:32];
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_EMIT;
        if (cmd_q == CMD_START) begin
          corner_x_d = in_x_q;
          corner_y_d = in_y_q;
          held_x_d   = in_x_q;
          held_y_d   = in_y_q;
          leg_d      = LEG_X_OUT;
          elapsed_d  = '0;
          finished_d = 1'b0;
        end else if (active) begin
          if (move) begin
            req.start = 1'b1;
            calc_x_d  = is_x;
            e_d       = e_full[TIME_BITS-1:0];
            state_d   = ST_CALC;
          end else begin
            if (is_x) begin
              held_x_d = p1;
            end else begin
              held_y_d = p1;
            end
            elapsed_d = '0;
            if (leg_q == LEG_Y_BACK) begin
              finished_d = 1'b1;
            end else begin
              leg_d = leg_q + 1'b1;
            end
          end
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          if (calc_x_q) begin
            held_x_d = calc_pos;
          end else begin
            held_y_d = calc_pos;
          end
          elapsed_d = e_q;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {held_y_q, held_x_q};
          m_user_d  = {finished_q, leg_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= CMD_TICK;
      in_x_q     <= '0;
      in_y_q     <= '0;
      corner_x_q <= '0;
      corner_y_q <= '0;
      held_x_q   <= '0;
      held_y_q   <= '0;
      leg_q      <= LEG_IDLE;
      elapsed_q  <= '0;
      finished_q <= 1'b0;
      calc_x_q   <= 1'b0;
      e_q        <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      in_x_q     <= in_x_d;
      in_y_q     <= in_y_d;
      corner_x_q <= corner_x_d;
      corner_y_q <= corner_y_d;
      held_x_q   <= held_x_d;
      held_y_q   <= held_y_d;
      leg_q      <= leg_d;
      elapsed_q  <= elapsed_d;
      finished_q <= finished_d;
      calc_x_q   <= calc_x_d;
      e_q        <= e_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_user_q   <= m_user_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_dx_q  <= '0;
      leg_dy_q  <= '0;
      ticks_x_q <= TIME_BITS'(LEG_TICKS_RST);
      ticks_y_q <= TIME_BITS'(LEG_TICKS_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEG_DX:  leg_dx_q  <= cfg_data_i[POS_W-1:0];
        REG_LEG_DY:  leg_dy_q  <= cfg_data_i[POS_W-1:0];
        REG_TICKS_X: ticks_x_q <= cfg_data_i[TIME_BITS-1:0];
        REG_TICKS_Y: ticks_y_q <= cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire
